>>> src/rcae_pkg.sv
// Shared constants and types for the ROC curve / AUC engine.
`default_nettype none
package rcae_pkg;
  localparam int MaxSamplesDefault = 32;
  localparam int ScoreBitsDefault  = 32;
  localparam int CntW   = 6;
  localparam int RateW  = 17;
  localparam int AreaW  = 12;
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOPOS = 2'd1;
  localparam logic [1:0] ST_NONEG = 2'd2;
  localparam logic [1:0] ST_OVF   = 2'd3;
  // divider request / response
  typedef struct packed {
    logic        start;
    logic [32:0] dividend;
    logic [12:0] divisor;
  } rcae_div_req_t;
  typedef struct packed {
    logic        done;
    logic [32:0] quotient;
  } rcae_div_rsp_t;
endpackage
`default_nettype wire

>>> src/roc_curve_auc_engine.sv
// Top level of the ROC curve / AUC engine.
// Channel | Dir | Ports                  | Payload
// in      | in  | in_tvalid/tready/tdata | tdata: score; tuser: is_positive; tlast: final_sample
// out     | out | out_tvalid/tready/tdata| tdata: counts, rates, area; tuser: status; tlast: end
// A non-final sample is stored and counted, or flags overflow once the RAM is full. A valid
// final sample runs an insertion sort over the sample RAMs (per sample a read, a wait and
// compares that shift until a put), then a walk over the ranked samples; each point runs the
// shared serial divider (33 steps) twice, and the closing point once more for the area.
// Synchronous active-low reset clears counts and sequencer; RAMs are not cleared.
// The walk pauses while a result waits in the output register; input waits meanwhile.
`default_nettype none
module roc_curve_auc_engine import rcae_pkg::*; #(
  parameter int MAX_SAMPLES = MaxSamplesDefault,
  parameter int SCORE_BITS  = ScoreBitsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // score[31:0]
  input  wire logic        in_tuser,   // is_positive
  input  wire logic        in_tlast,   // final_sample
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // fp_count[5:0] tp_count[11:6] fp_rate[28:12]
                                       // tp_rate[45:29] area[62:46] zero[63]
  output logic [1:0]       out_tuser,  // status
  output logic             out_tlast   // end_of_curve
);
  localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int KW = (SCORE_BITS < 32) ? SCORE_BITS : 32;
  localparam int RD = 1 << AW;

  typedef enum logic [4:0] {
    S_LOAD, S_SORT_I, S_SORT_RD, S_SORT_WK, S_SORT_CMP, S_SORT_PUT,
    S_WALK_RD, S_WALK_WK, S_WALK_CHK, S_DIV_FP, S_WAIT_FP, S_DIV_TP,
    S_WAIT_TP, S_EMIT, S_STEP, S_AUC, S_WAIT_AUC, S_FINAL
  } state_t;

  state_t st_r;
  logic [CntW-1:0] n_r, pos_r, neg_r;
  logic ovf_r;
  logic [AreaW-1:0] area_r;
  logic [AW:0] i_r, j_r;
  logic [KW-1:0] ki_r, prev_r;
  logic lab_r;
  logic have_r, lastpt_r;
  logic [CntW-1:0] fp_r, tp_r, fpp_r, tpp_r;
  logic [RateW-1:0] fpr_r, tpr_r, auc_r;
  logic [AW-1:0] shv_r;

  // RAM ports
  logic            s_we, o_we;
  logic [AW-1:0]   s_wa, s_ra, o_wa, o_ra, o_wd;
  logic [KW:0]     s_wd, s_rd;
  logic [AW-1:0]   o_rd;

  rcae_ram #(.WIDTH(KW+1), .DEPTH(RD)) u_smp (
    .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));
  rcae_ram #(.WIDTH(AW), .DEPTH(RD)) u_rank (
    .clk(clk), .we(o_we), .waddr(o_wa), .wdata(o_wd), .raddr(o_ra), .rdata(o_rd));

  rcae_div_req_t dreq;
  rcae_div_rsp_t drsp;
  rcae_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  logic in_xfer;
  assign in_tready = (st_r == S_LOAD) && !out_tvalid;
  assign in_xfer = in_tvalid && in_tready;

  logic [KW-1:0] key_in;
  assign key_in = in_tdata[KW-1:0] ^ {1'b1, {(KW-1){1'b0}}};
  logic room;
  assign room = ({1'b0, n_r} < 7'(MAX_SAMPLES));

  logic [AW:0] jm1;
  assign jm1 = j_r - 1'b1;

  always_comb begin
    s_we = in_xfer && room;
    s_wa = n_r[AW-1:0];
    s_wd = {in_tuser, key_in};
    o_we = 1'b0;
    o_wa = j_r[AW-1:0];
    o_wd = i_r[AW-1:0];
    o_ra = jm1[AW-1:0];
    s_ra = i_r[AW-1:0];
    case (st_r)
      S_SORT_RD:  s_ra = i_r[AW-1:0];
      S_SORT_WK:  s_ra = o_rd;
      S_SORT_CMP: begin
        s_ra = o_rd;
        if (j_r != '0 && s_rd[KW-1:0] < ki_r) begin
          o_we = 1'b1; o_wd = shv_r;
        end
      end
      S_SORT_PUT: o_we = 1'b1;
      S_WALK_RD:  o_ra = i_r[AW-1:0];
      S_WALK_WK:  s_ra = o_rd;
      default: ;
    endcase
  end

  // area step: (fp-fpp)*(tp+tpp), narrow multiply
  logic [13:0] area_prod;
  logic [AreaW-1:0] area_add;
  assign area_prod = {1'b0, fp_r - fpp_r} * ({1'b0, tp_r} + {1'b0, tpp_r});
  assign area_add = area_prod[AreaW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_LOAD; n_r <= '0; pos_r <= '0; neg_r <= '0; ovf_r <= 1'b0;
      area_r <= '0; out_tvalid <= 1'b0; dreq.start <= 1'b0;
    end else begin
      dreq.start <= (st_r == S_DIV_FP) || (st_r == S_DIV_TP) || (st_r == S_AUC);
      if (out_tvalid && out_tready) out_tvalid <= 1'b0;
      case (st_r)
        S_LOAD: if (in_xfer) begin
          if (in_tlast) begin
            if (!room || ovf_r || (pos_r == '0 && !(room && in_tuser))
                || (neg_r == '0 && !(room && !in_tuser))) begin
              out_tvalid <= 1'b1; out_tlast <= 1'b1; out_tdata <= '0;
              out_tuser <= (!room || ovf_r) ? ST_OVF :
                           (pos_r == '0 && !(room && in_tuser)) ? ST_NOPOS : ST_NONEG;
              n_r <= '0; pos_r <= '0; neg_r <= '0; ovf_r <= 1'b0;
            end else begin
              n_r <= n_r + 1'b1;
              if (in_tuser) pos_r <= pos_r + 1'b1; else neg_r <= neg_r + 1'b1;
              i_r <= '0; st_r <= S_SORT_I;
            end
          end else if (room) begin
            n_r <= n_r + 1'b1;
            if (in_tuser) pos_r <= pos_r + 1'b1; else neg_r <= neg_r + 1'b1;
          end else ovf_r <= 1'b1;
        end
        S_SORT_I: begin
          if ({1'b0, i_r} == 7'(n_r)) begin
            area_r <= '0; fp_r <= '0; tp_r <= '0; fpp_r <= '0; tpp_r <= '0;
            have_r <= 1'b0; i_r <= '0; st_r <= S_WALK_RD;
          end else begin
            j_r <= i_r; st_r <= S_SORT_RD;
          end
        end
        S_SORT_RD: st_r <= S_SORT_WK;   // score[i] read, rank[j-1] read
        S_SORT_WK: begin
          ki_r <= s_rd[KW-1:0]; shv_r <= o_rd;
          st_r <= (j_r == '0) ? S_SORT_PUT : S_SORT_CMP;
        end
        S_SORT_CMP: begin
          if (j_r != '0 && s_rd[KW-1:0] < ki_r) begin
            j_r <= jm1; st_r <= S_SORT_RD;
          end else st_r <= S_SORT_PUT;
        end
        S_SORT_PUT: begin
          i_r <= i_r + 1'b1; st_r <= S_SORT_I;
        end
        S_WALK_RD: st_r <= S_WALK_WK;
        S_WALK_WK: st_r <= S_WALK_CHK;
        S_WALK_CHK: begin
          // hold the ranked sample; the RAM read port moves on
          ki_r <= s_rd[KW-1:0]; lab_r <= s_rd[KW];
          if (!have_r || s_rd[KW-1:0] != prev_r) begin
            lastpt_r <= 1'b0; st_r <= S_DIV_FP;
          end else st_r <= S_STEP;
        end
        S_DIV_FP: begin
          dreq.dividend <= {11'd0, fp_r, 16'd0};
          dreq.divisor <= {7'd0, neg_r}; st_r <= S_WAIT_FP;
        end
        S_WAIT_FP: if (drsp.done) begin
          fpr_r <= drsp.quotient[RateW-1:0]; st_r <= S_DIV_TP;
        end
        S_DIV_TP: begin
          dreq.dividend <= {11'd0, tp_r, 16'd0};
          dreq.divisor <= {7'd0, pos_r}; st_r <= S_WAIT_TP;
        end
        S_WAIT_TP: if (drsp.done) begin
          tpr_r <= drsp.quotient[RateW-1:0];
          area_r <= area_r + area_add;
          fpp_r <= fp_r; tpp_r <= tp_r;
          st_r <= lastpt_r ? S_AUC : S_EMIT;
        end
        S_EMIT: if (!out_tvalid) begin
          out_tvalid <= 1'b1; out_tlast <= 1'b0; out_tuser <= ST_OK;
          out_tdata <= {1'b0, 17'd0, tpr_r, fpr_r, tp_r, fp_r};
          prev_r <= ki_r; have_r <= 1'b1; st_r <= S_STEP;
        end
        S_STEP: begin
          if (lab_r) tp_r <= tp_r + 1'b1; else fp_r <= fp_r + 1'b1;
          if ({1'b0, i_r} + 7'd1 == 7'(n_r)) begin
            lastpt_r <= 1'b1; st_r <= S_DIV_FP;
          end else begin
            i_r <= i_r + 1'b1; st_r <= S_WALK_RD;
          end
        end
        S_AUC: begin
          dreq.dividend <= {5'd0, area_r, 16'd0};
          dreq.divisor <= 13'({pos_r, 1'b0}) * 13'(neg_r);
          st_r <= S_WAIT_AUC;
        end
        S_WAIT_AUC: if (drsp.done) begin
          auc_r <= drsp.quotient[RateW-1:0]; st_r <= S_FINAL;
        end
        S_FINAL: if (!out_tvalid) begin
          out_tvalid <= 1'b1; out_tlast <= 1'b1; out_tuser <= ST_OK;
          out_tdata <= {1'b0, auc_r, tpr_r, fpr_r, tp_r, fp_r};
          n_r <= '0; pos_r <= '0; neg_r <= '0; ovf_r <= 1'b0;
          st_r <= S_LOAD;
        end
        default: st_r <= S_LOAD;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != S_LOAD |-> !in_tready) else $error("accept while busy");
  a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_LOAD |-> (pos_r + neg_r) == n_r) else $error("count mismatch");
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tlast) else $error("error not last");
`endif
endmodule
`default_nettype wire

>>> src/rcae_ram.sv
// Generic single-port-write RAM with registered read.
`default_nettype none
module rcae_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> src/rcae_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module rcae_div import rcae_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire rcae_div_req_t req,
  output rcae_div_rsp_t      rsp
);
  logic [32:0] q_r;
  logic [12:0] rem_r;
  logic [12:0] dv_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [13:0] trial;
  logic [13:0] diff;
  assign trial = {rem_r, q_r[32]};
  assign diff  = trial - {1'b0, dv_r};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && !req.start && (cnt_r == 6'd1);
      if (req.start) begin
        busy_r <= 1'b1;
        q_r    <= req.dividend;
        rem_r  <= '0;
        dv_r   <= req.divisor;
        cnt_r  <= 6'd33;
      end else if (busy_r) begin
        // remainder stays below the divisor, so it fits in 13 bits
        if (trial >= {1'b0, dv_r}) begin
          rem_r <= diff[12:0];
          q_r   <= {q_r[31:0], 1'b1};
        end else begin
          rem_r <= trial[12:0];
          q_r   <= {q_r[31:0], 1'b0};
        end
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) busy_r <= 1'b0;
      end
    end
  end
  assign rsp = '{done: done_r, quotient: q_r};
endmodule
`default_nettype wire

>>> dv/tb_roc_curve_auc_engine.sv
// Testbench for the ROC curve / AUC engine: scored sample sets in, ROC points checked out.
`timescale 1ns / 1ps
`default_nettype none
module tb_roc_curve_auc_engine import rcae_pkg::*; ();

  typedef struct packed {
    logic [5:0]  fp_cnt;
    logic [5:0]  tp_cnt;
    logic [16:0] fp_rate;
    logic [16:0] tp_rate;
    logic [16:0] area;
    logic        eoc;
    logic [1:0]  status;
  } roc_point_t;

  class roc_scoreboard;
    logic [31:0] score_q[$];
    bit          label_q[$];
    int unsigned pos_total, neg_total;
    bit          overflow;
    roc_point_t  pending[$];
    int          mismatches;

    function void add_point(int unsigned fp, int unsigned tp, int unsigned area,
                            bit eoc, logic [1:0] st);
      roc_point_t p;
      longint unsigned fr, tr;
      fr = 0;
      tr = 0;
      if (st == ST_OK) begin
        fr = (longint'(fp) << 16) / neg_total;
        tr = (longint'(tp) << 16) / pos_total;
      end
      p.fp_cnt = fp[5:0];
      p.tp_cnt = tp[5:0];
      p.fp_rate = fr[16:0];
      p.tp_rate = tr[16:0];
      p.area = area[16:0];
      p.eoc = eoc;
      p.status = st;
      pending.push_back(p);
    endfunction

    // Records the sample; on the final one, ranks the set by descending score (stable) and walks it.
    function void note_sample(logic [31:0] score, bit pos, bit last);
      int unsigned order[$];
      int unsigned n, j, tmp, fp, tp, fpp, tpp, dbl, auc;
      logic [31:0] prev;
      bit have;
      if (score_q.size() < 32) begin
        score_q.push_back(score ^ 32'h8000_0000);
        label_q.push_back(pos);
        if (pos) pos_total++; else neg_total++;
      end else begin
        overflow = 1;
      end
      if (!last) return;
      if (overflow || pos_total == 0 || neg_total == 0) begin
        add_point(0, 0, 0, 1, overflow ? ST_OVF : (pos_total == 0 ? ST_NOPOS : ST_NONEG));
      end else begin
        n = score_q.size();
        for (int i = 0; i < n; i++) begin
          order.push_back(i);
          j = i;
          while (j > 0 && score_q[order[j-1]] < score_q[order[j]]) begin
            tmp = order[j]; order[j] = order[j-1]; order[j-1] = tmp;
            j--;
          end
        end
        fp = 0; tp = 0; fpp = 0; tpp = 0; dbl = 0; have = 0; prev = '0;
        for (int i = 0; i < n; i++) begin
          if (!have || score_q[order[i]] != prev) begin
            add_point(fp, tp, 0, 0, ST_OK);
            dbl += (fp - fpp) * (tp + tpp);
            fpp = fp; tpp = tp; prev = score_q[order[i]]; have = 1;
          end
          if (label_q[order[i]]) tp++; else fp++;
        end
        dbl += (fp - fpp) * (tp + tpp);
        dbl &= 12'hFFF;
        auc = (longint'(dbl) << 16) / (2 * pos_total * neg_total);
        add_point(fp, tp, auc, 1, ST_OK);
      end
      score_q.delete();
      label_q.delete();
      pos_total = 0;
      neg_total = 0;
      overflow = 0;
    endfunction

    function void check_point(roc_point_t got);
      roc_point_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: fp %0d/%0d tp %0d/%0d fpr %0d/%0d tpr %0d/%0d",
                    " auc %0d/%0d eoc %0d/%0d st %0d/%0d"},
                   want.fp_cnt, got.fp_cnt, want.tp_cnt, got.tp_cnt,
                   want.fp_rate, got.fp_rate, want.tp_rate, got.tp_rate,
                   want.area, got.area, want.eoc, got.eoc, want.status, got.status);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tuser = 0;
  logic        in_tlast = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [63:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_off = 0;
  roc_scoreboard sb = new();

  roc_curve_auc_engine uut (.*);

  always #5 clk = ~clk;

  // one sample transfer; valid stays up into the next call unless the sender idles
  task automatic send_sample(logic [31:0] score, bit pos, bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= score;
    in_tuser <= pos;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    sb.note_sample(score, pos, last);
  endtask

  function automatic logic [31:0] rand_score();
    case ($urandom_range(3))
      0: return $urandom_range(7) - 4;
      1: return {$urandom_range(1) ? 32'h7FFF_FFF0 : 32'h8000_0000} + $urandom_range(15);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_set(int n);
    for (int i = 0; i < n; i++)
      send_sample(rand_score(), $urandom_range(1), i == n - 1);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_point({out_tdata[5:0], out_tdata[11:6], out_tdata[28:12], out_tdata[45:29],
                      out_tdata[62:46], out_tlast, out_tuser});
    out_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    int cnt;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: extremes, ties, single-class errors, overflow
    send_sample(32'h7FFF_FFFF, 1, 0);
    send_sample(32'h8000_0000, 0, 0);
    send_sample(32'h0, 1, 0);
    send_sample(32'h0, 0, 0);
    send_sample(32'hFFFF_FFFF, 0, 1);
    send_sample(32'h5, 1, 0);
    send_sample(32'h5, 0, 1);
    send_sample(32'h1, 1, 0);
    send_sample(32'h2, 1, 1);
    send_sample(32'h1, 0, 1);
    send_sample(32'h3, 0, 0);
    send_sample(32'h3, 1, 1);
    for (int i = 0; i < 34; i++) send_sample($urandom, i[0], i == 33);
    for (int i = 0; i < 32; i++) send_sample(i[0] ? 32'h10 : 32'h20, i < 16, i == 31);
    drain();
    cnt = 0;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 54 : 10) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 54 : 10) : 0;
      while (cnt < 30 * (ph + 1)) begin
        int n;
        n = ($urandom_range(9) == 0) ? $urandom_range(36) + 1 : $urandom_range(10) + 1;
        send_set(n);
        cnt += n;
      end
      drain();
    end
    // long receiver hold-off while the sender keeps offering
    fork
      begin
        hold_off = 1;
        repeat (3000) @(posedge clk);
        hold_off = 0;
      end
      begin
        send_set(3); send_set(4); send_set(2);
      end
    join
    drain();
    if (sb.mismatches == 0 && sb.pending.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #50_000_000;
    $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
src/rcae_pkg.sv
src/rcae_ram.sv
src/rcae_div.sv
src/roc_curve_auc_engine.sv
dv/tb_roc_curve_auc_engine.sv
